// ===== rtl/core/nsti_pkg.sv =====
// ============================================================================
// nsti_pkg
// Types, character codes and helper functions for the numeric string to
// integer converter.
// ============================================================================
`default_nettype none

package nsti_pkg;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } nsti_phase_t;

    typedef struct packed {
        nsti_phase_t phase;
        logic        negative;
        logic [5:0]  active_base;
    } nsti_ctl_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } nsti_in_t;

    typedef struct packed {
        logic [63:0] number;
        logic [5:0]  base_used;
    } nsti_out_t;

    localparam nsti_ctl_t CTL_RESET = '{phase: PH_START, negative: 1'b0, active_base: 6'd0};

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_X_LOW  = 8'h78;
    localparam logic [7:0] CHAR_X_UP   = 8'h58;
    localparam logic [7:0] NO_DIGIT    = 8'hFF;

    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_DEC = 6'd10;
    localparam logic [5:0] BASE_HEX = 6'd16;

    localparam logic [1:0] CFG_RADIX     = 2'd0;
    localparam logic [1:0] CFG_WIDTH_SEL = 2'd1;
    localparam logic [1:0] CFG_STOP_NUL  = 2'd2;

    localparam logic [1:0] WSEL_16 = 2'd0;
    localparam logic [1:0] WSEL_32 = 2'd1;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h37;
        end
        return d;
    endfunction

    function automatic logic [63:0] width_mask(input logic [1:0] sel);
        logic [63:0] m;
        case (sel)
            WSEL_16: begin
                m = 64'h0000_0000_0000_FFFF;
            end
            WSEL_32: begin
                m = 64'h0000_0000_FFFF_FFFF;
            end
            default: begin
                m = '1;
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nsti_char_step.sv =====
// ============================================================================
// nsti_char_step
// Applies one character to the parse state: sign, prefix detection, digit
// filtering and the multiply-add into the accumulator.
// ============================================================================
`default_nettype none

module nsti_char_step
    import nsti_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic [7:0]             char_in,
    input  wire logic                   is_last,
    input  wire logic [5:0]             radix,
    input  wire logic                   stop_at_nul,
    input  wire nsti_ctl_t              ctl_cur,
    input  wire logic [VALUE_WIDTH-1:0] accum_cur,
    output nsti_ctl_t                   ctl_nxt,
    output logic [VALUE_WIDTH-1:0]      accum_nxt,
    output logic                        str_end,
    output logic [5:0]                  base_out
);

    logic [5:0]  pre_base;
    logic [7:0]  dval;
    logic        end_nul;
    logic        sign_taken;
    logic        take_digit;
    nsti_phase_t ph_work;

    assign pre_base = (radix == 6'd0) ? BASE_DEC : radix;
    assign dval     = digit_value(char_in);
    assign end_nul  = stop_at_nul && (char_in == CHAR_NUL);
    assign str_end  = end_nul || is_last;

    always_comb begin
        ctl_nxt    = ctl_cur;
        take_digit = 1'b0;
        sign_taken = 1'b0;
        ph_work    = ctl_cur.phase;
        if (!end_nul) begin
            if (ph_work == PH_START) begin
                ph_work       = PH_SKIP;
                ctl_nxt.phase = PH_SKIP;
                if (char_in == CHAR_MINUS) begin
                    ctl_nxt.negative = 1'b1;
                    sign_taken       = 1'b1;
                end
            end
            if (!sign_taken) begin
                case (ph_work)
                    PH_SKIP: begin
                        if (dval < {2'b00, pre_base}) begin
                            if (radix == 6'd0) begin
                                if (char_in == CHAR_ZERO) begin
                                    ctl_nxt.phase = PH_ZERO;
                                end else begin
                                    ctl_nxt.active_base = BASE_DEC;
                                    ctl_nxt.phase       = PH_DIGITS;
                                    take_digit          = 1'b1;
                                end
                            end else begin
                                ctl_nxt.active_base = radix;
                                ctl_nxt.phase       = PH_DIGITS;
                                take_digit          = 1'b1;
                            end
                        end
                    end
                    PH_ZERO: begin
                        ctl_nxt.phase = PH_DIGITS;
                        if (char_in == CHAR_X_LOW || char_in == CHAR_X_UP) begin
                            ctl_nxt.active_base = BASE_HEX;
                        end else begin
                            ctl_nxt.active_base = BASE_OCT;
                            take_digit          = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        take_digit = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        accum_nxt = accum_cur;
        if (take_digit && (dval < {2'b00, ctl_nxt.active_base})) begin
            accum_nxt = accum_cur * VALUE_WIDTH'(ctl_nxt.active_base)
                      + VALUE_WIDTH'(dval[5:0]);
        end
    end

    always_comb begin
        case (ctl_nxt.phase)
            PH_DIGITS: begin
                base_out = ctl_nxt.active_base;
            end
            PH_ZERO: begin
                base_out = BASE_OCT;
            end
            default: begin
                base_out = pre_base;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/numeric_string_to_integer_unit.sv =====
// ============================================================================
// numeric_string_to_integer_unit
// Streaming string to integer converter with C style base prefix detection.
// ============================================================================
// Characters enter on the s_ channel, one per transfer, with is_last marking
// the final character of a string. With stop_at_nul set, a NUL character also
// ends the string and is itself not parsed. One result per string leaves on
// the m_ channel: the value, negated for a leading minus sign and wrapped to
// the selected width, and the base that was applied.
// A character transfer is taken every cycle while s_ready is high. The
// character is held in the input register, then the multiply-add by the
// base updates the accumulator, or for the final character loads the middle
// stage; negate and width mask then fill the output register behind m_valid.
// The critical path is the accumulator times base plus digit.
// When the receiver stalls, the result stays in the output register, one
// more result waits in the middle stage, and s_ready drops only when a
// further string end would have nowhere to go.
// Reset clears all string state and sets radix 0, 32-bit width and NUL stop.
// Configuration writes are taken every cycle and belong in idle periods.
// ============================================================================
`default_nettype none

module numeric_string_to_integer_unit
    import nsti_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire nsti_in_t   s_payload,
    output logic            m_valid,
    input  wire logic       m_ready,
    output nsti_out_t       m_payload,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic                   in_valid_reg;
    nsti_in_t               in_data_reg;
    logic [5:0]             radix_reg;
    logic [1:0]             width_sel_reg;
    logic                   stop_nul_reg;
    nsti_ctl_t              ctl_reg;
    nsti_ctl_t              ctl_next;
    logic [VALUE_WIDTH-1:0] accum_reg;
    logic [VALUE_WIDTH-1:0] accum_next;
    logic                   mid_valid_reg;
    logic [VALUE_WIDTH-1:0] mid_accum_reg;
    logic                   mid_neg_reg;
    logic [5:0]             mid_base_reg;
    logic                   out_valid_reg;
    nsti_out_t              out_data_reg;

    nsti_ctl_t              step_ctl;
    logic [VALUE_WIDTH-1:0] step_accum;
    logic                   step_end;
    logic [5:0]             step_base;
    logic                   a_fire;
    logic                   mid_fire;
    logic [VALUE_WIDTH-1:0] signed_val;

    nsti_char_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .char_in    (in_data_reg.char_in),
        .is_last    (in_data_reg.is_last),
        .radix      (radix_reg),
        .stop_at_nul(stop_nul_reg),
        .ctl_cur    (ctl_reg),
        .accum_cur  (accum_reg),
        .ctl_nxt    (step_ctl),
        .accum_nxt  (step_accum),
        .str_end    (step_end),
        .base_out   (step_base)
    );

    assign mid_fire  = mid_valid_reg && (!out_valid_reg || m_ready);
    assign a_fire    = in_valid_reg && (!step_end || !mid_valid_reg || mid_fire);
    assign s_ready   = !in_valid_reg || a_fire;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    assign signed_val = mid_neg_reg ? (VALUE_WIDTH'(0) - mid_accum_reg) : mid_accum_reg;

    always_comb begin
        ctl_next   = ctl_reg;
        accum_next = accum_reg;
        if (a_fire) begin
            if (step_end) begin
                ctl_next   = CTL_RESET;
                accum_next = '0;
            end else begin
                ctl_next   = step_ctl;
                accum_next = step_accum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            radix_reg     <= 6'd0;
            width_sel_reg <= WSEL_32;
            stop_nul_reg  <= 1'b1;
            ctl_reg       <= CTL_RESET;
            accum_reg     <= '0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_RADIX: begin
                        radix_reg <= cfg_data[5:0];
                    end
                    CFG_WIDTH_SEL: begin
                        width_sel_reg <= cfg_data[1:0];
                    end
                    CFG_STOP_NUL: begin
                        stop_nul_reg <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            ctl_reg   <= ctl_next;
            accum_reg <= accum_next;
            if (a_fire && step_end) begin
                mid_valid_reg <= 1'b1;
            end else if (mid_fire) begin
                mid_valid_reg <= 1'b0;
            end
            if (mid_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_payload;
        end
        if (a_fire && step_end) begin
            mid_accum_reg <= step_accum;
            mid_neg_reg   <= step_ctl.negative;
            mid_base_reg  <= step_base;
        end
        if (mid_fire) begin
            out_data_reg.number    <= 64'(signed_val) & width_mask(width_sel_reg);
            out_data_reg.base_used <= mid_base_reg;
        end
    end

    a_base_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.base_used != 6'd0))
        else $error("result reports a zero base");

    a_width16_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && width_sel_reg == WSEL_16) |-> (m_payload.number[63:16] == 48'd0))
        else $error("16-bit result has upper bits set");

    a_digits_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg.phase == PH_DIGITS) |-> (ctl_reg.active_base != 6'd0))
        else $error("digit phase without an active base");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && step_end) |=> (ctl_reg == CTL_RESET && accum_reg == '0))
        else $error("string state not cleared after a string end");

    a_mid_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid_reg && !mid_fire) |=> mid_valid_reg && $stable(mid_accum_reg))
        else $error("pending result lost or overwritten");

endmodule

`default_nettype wire
